@@ sv/rcmp_pkg.sv @@
// Shared types and constants of the stereo RMS compander.
`timescale 1ns / 1ps
`default_nettype none
package rcmp_pkg;

	localparam logic [47:0] POWER_MAX   = 48'hFFFF_FFFF_FFFF;
	localparam logic [47:0] POWER_RESET = 48'd109951162778;
	localparam logic [63:0] RMS_EPS     = 64'd110;
	localparam logic [31:0] ENC_GMIN    = 32'd104858;
	localparam logic [31:0] ENC_GMAX    = 32'd10485760;
	localparam logic [31:0] DEC_GMIN    = 32'd52429;
	localparam logic [31:0] DEC_GMAX    = 32'd20971520;
	localparam logic [24:0] COEFF_ONE   = 25'h100_0000;
	localparam logic [64:0] DEC_LIMIT   = 65'd400 << 40;

	localparam int IDX_W  = 3;
	localparam int DATA_W = 24;

	localparam logic [IDX_W-1:0] CFG_ENABLE    = 3'd0;
	localparam logic [IDX_W-1:0] CFG_DIRECTION = 3'd1;
	localparam logic [IDX_W-1:0] CFG_ATTACK    = 3'd2;
	localparam logic [IDX_W-1:0] CFG_RELEASE   = 3'd3;
	localparam logic [IDX_W-1:0] CFG_REFERENCE = 3'd4;

	localparam logic [23:0] ATTACK_RESET    = 24'd16742299;
	localparam logic [23:0] RELEASE_RESET   = 24'd16776051;
	localparam logic [22:0] REFERENCE_RESET = 23'd331350;

	typedef struct packed {
		logic        direction;
		logic [23:0] attack_coeff;
		logic [23:0] release_coeff;
		logic [22:0] reference_level;
	} rcmp_cfg_t;

endpackage
`default_nettype wire

@@ sv/rcmp_if.sv @@
// Handshake channels of the stereo RMS compander: sample in, sample out, register write.
`timescale 1ns / 1ps
`default_nettype none
interface rcmp_in_if #(parameter int SAMPLE_BITS = 24);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_sample;
	logic signed [SAMPLE_BITS-1:0] right_sample;
	modport source(output valid, left_sample, right_sample, input ready);
	modport sink(input valid, left_sample, right_sample, output ready);
endinterface

interface rcmp_out_if #(parameter int SAMPLE_BITS = 24);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_out;
	logic signed [SAMPLE_BITS-1:0] right_out;
	modport source(output valid, left_out, right_out, input ready);
	modport sink(input valid, left_out, right_out, output ready);
endinterface

interface rcmp_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [rcmp_pkg::IDX_W-1:0]    index;
	logic [rcmp_pkg::DATA_W-1:0]   data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ sv/rms_compander_encode_decode.sv @@
// Top level of the stereo RMS compander: register port, channel sequencing, output register.
// With the compander on, each input beat makes two passes through the shared core, left then
// right; a pass runs a 32-step root, the 65-step divider and a second 32-step root, but a
// decode overflow skips the second root. With the compander off, the beat goes straight
// to the output register. No new pair is taken while the core works on one; the next pair
// is taken while the previous result waits in the output register. Reset: registers take
// their defaults and both power trackers start at 0.1.
`timescale 1ns / 1ps
`default_nettype none
module rms_compander_encode_decode #(
	parameter int SAMPLE_BITS = 24
) (
	input  wire logic clk,
	input  wire logic arst_n,
	rcmp_in_if.sink   sample_in,
	rcmp_out_if.source sample_out,
	rcmp_cfg_if.sink  cfg
);

	typedef enum logic [3:0] {
		T_IDLE  = 4'b0001,
		T_LEFT  = 4'b0010,
		T_RIGHT = 4'b0100,
		T_PUSH  = 4'b1000
	} top_state_t;

	top_state_t                    state_q;
	logic                          start_q;
	logic                          enable_q;
	rcmp_pkg::rcmp_cfg_t           cfg_q;
	logic signed [SAMPLE_BITS-1:0] in_l_q;
	logic signed [SAMPLE_BITS-1:0] in_r_q;
	logic signed [SAMPLE_BITS-1:0] res_l_q;
	logic signed [SAMPLE_BITS-1:0] res_r_q;
	logic signed [SAMPLE_BITS-1:0] out_l_q;
	logic signed [SAMPLE_BITS-1:0] out_r_q;
	logic [47:0]                   pow_l_q;
	logic [47:0]                   pow_r_q;
	logic                          out_valid_q;

	logic                          in_acc;
	logic                          cfg_acc;
	logic                          slot_free;
	logic                          core_done;
	logic signed [SAMPLE_BITS-1:0] core_res;
	logic [47:0]                   core_pow;
	logic signed [SAMPLE_BITS-1:0] core_sample;
	logic [47:0]                   core_pow_in;

	assign sample_in.ready = (state_q == T_IDLE);
	assign cfg.ready       = 1'b1;
	assign in_acc          = sample_in.valid && sample_in.ready;
	assign cfg_acc         = cfg.valid && cfg.ready;
	assign slot_free       = !out_valid_q || sample_out.ready;
	assign core_sample     = (state_q == T_RIGHT) ? in_r_q : in_l_q;
	assign core_pow_in     = (state_q == T_RIGHT) ? pow_r_q : pow_l_q;

	rcmp_core #(.SAMPLE_BITS(SAMPLE_BITS)) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start_q),
		.sample  (core_sample),
		.pow_in  (core_pow_in),
		.cfg     (cfg_q),
		.done    (core_done),
		.result  (core_res),
		.pow_out (core_pow)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q              <= 1'b1;
			cfg_q.direction       <= 1'b0;
			cfg_q.attack_coeff    <= rcmp_pkg::ATTACK_RESET;
			cfg_q.release_coeff   <= rcmp_pkg::RELEASE_RESET;
			cfg_q.reference_level <= rcmp_pkg::REFERENCE_RESET;
		end else if (cfg_acc) begin
			unique case (cfg.index)
				rcmp_pkg::CFG_ENABLE:    enable_q              <= cfg.data[0];
				rcmp_pkg::CFG_DIRECTION: cfg_q.direction       <= cfg.data[0];
				rcmp_pkg::CFG_ATTACK:    cfg_q.attack_coeff    <= cfg.data[23:0];
				rcmp_pkg::CFG_RELEASE:   cfg_q.release_coeff   <= cfg.data[23:0];
				rcmp_pkg::CFG_REFERENCE: cfg_q.reference_level <= cfg.data[22:0];
				default: begin
					enable_q <= enable_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
			pow_l_q     <= rcmp_pkg::POWER_RESET;
			pow_r_q     <= rcmp_pkg::POWER_RESET;
		end else begin
			start_q <= (state_q == T_IDLE && in_acc && enable_q) ||
				(state_q == T_LEFT && core_done);
			if (state_q == T_PUSH && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && sample_out.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				T_IDLE: begin
					if (in_acc) begin
						if (enable_q) begin
							state_q <= T_LEFT;
						end else begin
							state_q <= T_PUSH;
						end
					end
				end
				T_LEFT: begin
					if (core_done) begin
						pow_l_q <= core_pow;
						state_q <= T_RIGHT;
					end
				end
				T_RIGHT: begin
					if (core_done) begin
						pow_r_q <= core_pow;
						state_q <= T_PUSH;
					end
				end
				T_PUSH: begin
					if (slot_free) begin
						state_q <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			in_l_q  <= sample_in.left_sample;
			in_r_q  <= sample_in.right_sample;
			res_l_q <= sample_in.left_sample;
			res_r_q <= sample_in.right_sample;
		end
		if (core_done && state_q == T_LEFT) begin
			res_l_q <= core_res;
		end
		if (core_done && state_q == T_RIGHT) begin
			res_r_q <= core_res;
		end
		if (state_q == T_PUSH && slot_free) begin
			out_l_q <= res_l_q;
			out_r_q <= res_r_q;
		end
	end

	assign sample_out.valid     = out_valid_q;
	assign sample_out.left_out  = out_l_q;
	assign sample_out.right_out = out_r_q;

	a_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		core_done |-> (state_q == T_LEFT || state_q == T_RIGHT))
		else $error("core finished outside a channel pass");

	a_start_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |=> !start_q)
		else $error("core start held longer than one cycle");

	a_bypass: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !enable_q) |=> (state_q == T_PUSH))
		else $error("bypass beat did not go straight to output");

	a_push_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == T_PUSH && !out_valid_q) |=> out_valid_q)
		else $error("free output register not loaded");

endmodule
`default_nettype wire

@@ sv/rcmp_mul.sv @@
// Shared 32x32 unsigned multiplier with registered product.
`timescale 1ns / 1ps
`default_nettype none
module rcmp_mul (
	input  wire logic        clk,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic      [63:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= 64'(a) * 64'(b);
	end

endmodule
`default_nettype wire

@@ sv/rcmp_core.sv @@
// Sequencer run once per channel pass: power tracking, square roots, division and gain multiply.
`timescale 1ns / 1ps
`default_nettype none
module rcmp_core #(
	parameter int SAMPLE_BITS = 24
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic signed [SAMPLE_BITS-1:0] sample,
	input  wire logic        [47:0]            pow_in,
	input  wire rcmp_pkg::rcmp_cfg_t           cfg,
	output logic                               done,
	output logic signed      [SAMPLE_BITS-1:0] result,
	output logic             [47:0]            pow_out
);

	localparam logic [43:0] LIM    = 44'(1) << (SAMPLE_BITS - 1);
	localparam logic [43:0] LIM_M1 = LIM - 44'd1;

	typedef enum logic [6:0] {
		C_IDLE = 7'b0000001,
		C_MUL  = 7'b0000010,
		C_SQ1  = 7'b0000100,
		C_DIV  = 7'b0001000,
		C_SQ2  = 7'b0010000,
		C_OMUL = 7'b0100000,
		C_DONE = 7'b1000000
	} core_state_t;

	core_state_t             state_q;
	logic [6:0]              cnt_q;
	logic [SAMPLE_BITS-1:0]  mag_q;
	logic                    neg_q;
	logic [47:0]             pow_q;
	logic [47:0]             x2_q;
	logic [24:0]             c_q;
	logic [24:0]             d_q;
	logic [73:0]             acc_q;
	logic [63:0]             rad_q;
	logic [35:0]             rem_q;
	logic [31:0]             root_q;
	logic [64:0]             dq_q;
	logic [24:0]             dvs_q;
	logic [24:0]             gain_q;
	logic [SAMPLE_BITS-1:0]  res_q;

	logic [31:0]             mul_a;
	logic [31:0]             mul_b;
	logic [63:0]             p_q;
	logic [35:0]             sub_a;
	logic [35:0]             sub_b;
	logic [36:0]             diff;
	logic                    ge;
	logic [31:0]             root_n;
	logic [SAMPLE_BITS-1:0]  mag_n;
	logic [47:0]             x2_n;
	logic [23:0]             csel;
	logic [73:0]             acc_fin;
	logic [22:0]             refv;
	logic [64:0]             q_fin;
	logic [31:0]             glo;
	logic [31:0]             ghi;
	logic [31:0]             gcl;
	logic [63:0]             rnd_sum;
	logic [43:0]             r_n;
	logic [43:0]             r_neg;
	logic [43:0]             r_pos;
	logic [SAMPLE_BITS-1:0]  out_n;

	rcmp_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (p_q)
	);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == C_MUL) begin
			case (cnt_q)
				7'd0: begin
					mul_a = 32'(mag_q);
					mul_b = 32'(mag_q);
				end
				7'd2: begin
					mul_a = 32'(c_q);
					mul_b = 32'(pow_q[23:0]);
				end
				7'd3: begin
					mul_a = 32'(c_q);
					mul_b = 32'(pow_q[47:24]);
				end
				7'd4: begin
					mul_a = 32'(d_q);
					mul_b = 32'(x2_q[23:0]);
				end
				7'd5: begin
					mul_a = 32'(d_q);
					mul_b = 32'(x2_q[47:24]);
				end
				default: begin
					mul_a = '0;
					mul_b = '0;
				end
			endcase
		end else if (state_q == C_OMUL) begin
			mul_a = 32'(gain_q);
			mul_b = 32'(mag_q);
		end
	end

	always_comb begin
		if (state_q == C_DIV) begin
			sub_a = 36'({rem_q[24:0], dq_q[64]});
			sub_b = 36'(dvs_q);
		end else begin
			sub_a = {rem_q[33:0], rad_q[63:62]};
			sub_b = {2'b00, root_q, 2'b01};
		end
		diff   = {1'b0, sub_a} - {1'b0, sub_b};
		ge     = !diff[36];
		root_n = {root_q[30:0], ge};
	end

	always_comb begin
		mag_n   = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
		x2_n    = (p_q > 64'(rcmp_pkg::POWER_MAX)) ? rcmp_pkg::POWER_MAX : p_q[47:0];
		csel    = (x2_n > pow_q) ? cfg.attack_coeff : cfg.release_coeff;
		acc_fin = acc_q + (74'(p_q) << 24);
		refv    = (cfg.reference_level == '0) ? 23'd1 : cfg.reference_level;
		q_fin   = {dq_q[63:0], ge};
		glo     = cfg.direction ? rcmp_pkg::DEC_GMIN : rcmp_pkg::ENC_GMIN;
		ghi     = cfg.direction ? rcmp_pkg::DEC_GMAX : rcmp_pkg::ENC_GMAX;
		gcl     = (root_n < glo) ? glo : ((root_n > ghi) ? ghi : root_n);
		rnd_sum = p_q + 64'h8_0000;
		r_n     = rnd_sum[63:20];
		r_neg   = (r_n > LIM) ? LIM : r_n;
		r_pos   = (r_n > LIM_M1) ? LIM_M1 : r_n;
		out_n   = neg_q ? SAMPLE_BITS'(44'd0 - r_neg) : SAMPLE_BITS'(r_pos);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				C_IDLE: begin
					if (start) begin
						state_q <= C_MUL;
						cnt_q   <= '0;
					end
				end
				C_MUL: begin
					if (cnt_q == 7'd6) begin
						state_q <= C_SQ1;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				C_SQ1: begin
					if (cnt_q == 7'd31) begin
						state_q <= C_DIV;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				C_DIV: begin
					if (cnt_q == 7'd64) begin
						cnt_q <= '0;
						if (cfg.direction && q_fin >= rcmp_pkg::DEC_LIMIT) begin
							state_q <= C_OMUL;
						end else begin
							state_q <= C_SQ2;
						end
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				C_SQ2: begin
					if (cnt_q == 7'd31) begin
						state_q <= C_OMUL;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				C_OMUL: begin
					if (cnt_q == 7'd1) begin
						state_q <= C_DONE;
					end
					cnt_q <= cnt_q + 7'd1;
				end
				C_DONE: begin
					state_q <= C_IDLE;
				end
				default: begin
					state_q <= C_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			C_IDLE: begin
				if (start) begin
					mag_q <= mag_n;
					neg_q <= sample[SAMPLE_BITS-1];
					pow_q <= pow_in;
				end
			end
			C_MUL: begin
				case (cnt_q)
					7'd1: begin
						x2_q <= x2_n;
						c_q  <= 25'(csel);
						d_q  <= rcmp_pkg::COEFF_ONE - 25'(csel);
					end
					7'd3: acc_q <= 74'(p_q);
					7'd4: acc_q <= acc_q + (74'(p_q) << 24);
					7'd5: acc_q <= acc_q + 74'(p_q);
					7'd6: begin
						pow_q  <= acc_fin[71:24];
						rad_q  <= 64'(acc_fin[71:24]) + rcmp_pkg::RMS_EPS;
						rem_q  <= '0;
						root_q <= '0;
					end
					default: begin
						acc_q <= acc_q;
					end
				endcase
			end
			C_SQ1, C_SQ2: begin
				rem_q  <= (cnt_q == 7'd31) ? 36'd0 : (ge ? diff[35:0] : sub_a);
				root_q <= root_n;
				rad_q  <= {rad_q[61:0], 2'b00};
				if (cnt_q == 7'd31) begin
					if (state_q == C_SQ1) begin
						if (cfg.direction) begin
							dq_q  <= 65'(root_n[24:0]) << 40;
							dvs_q <= 25'(refv);
						end else begin
							dq_q  <= 65'(refv) << 40;
							dvs_q <= root_n[24:0];
						end
					end else begin
						gain_q <= gcl[24:0];
					end
				end
			end
			C_DIV: begin
				rem_q <= (cnt_q == 7'd64) ? 36'd0 : (ge ? diff[35:0] : sub_a);
				dq_q  <= q_fin;
				if (cnt_q == 7'd64) begin
					rad_q  <= q_fin[63:0];
					root_q <= '0;
					gain_q <= rcmp_pkg::DEC_GMAX[24:0];
				end
			end
			C_OMUL: begin
				if (cnt_q == 7'd1) begin
					res_q <= out_n;
				end
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign done    = (state_q == C_DONE);
	assign result  = res_q;
	assign pow_out = pow_q;

endmodule
`default_nettype wire

@@ dv/rms_compander_encode_decode_tb.sv @@
// Testbench of the stereo RMS compander: directed table and random pairs against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module rms_compander_encode_decode_tb;

	localparam logic [rcmp_pkg::IDX_W-1:0] CFG_UNUSED = 3'd7;

	typedef struct {
		logic signed [23:0] left;
		logic signed [23:0] right;
	} pair_t;

	typedef struct {
		logic signed [23:0] left;
		logic signed [23:0] right;
		bit                 known;
		logic signed [23:0] exp_left;
		logic signed [23:0] exp_right;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rcmp_in_if  #(.SAMPLE_BITS(24)) sample_in ();
	rcmp_out_if #(.SAMPLE_BITS(24)) sample_out ();
	rcmp_cfg_if cfg ();

	rms_compander_encode_decode #(.SAMPLE_BITS(24)) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample_in  (sample_in),
		.sample_out (sample_out),
		.cfg        (cfg)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("Mismatches found");
		$finish;
	end

	bit         m_enable;
	bit         m_direction;
	bit [23:0]  m_attack;
	bit [23:0]  m_release;
	bit [22:0]  m_reference;
	bit [47:0]  m_power_l;
	bit [47:0]  m_power_r;

	pair_t expected_pairs[$];
	int    mismatches;
	int    results_seen;
	int    send_idle_pct;
	int    recv_idle_pct;
	int    hold_off;

	function automatic bit [63:0] int_sqrt(bit [63:0] v);
		bit [63:0] r;
		bit [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic bit [63:0] bound(bit [63:0] v, bit [63:0] lo, bit [63:0] hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic logic signed [23:0] compand_channel(logic signed [23:0] s,
			ref bit [47:0] pw);
		bit [63:0] mag, sq, refl, rms, gain, prod, rnd, qi, q, c, d, hi, lo, pw64;
		longint    outv;
		mag = (s < 0) ? 64'(-longint'(s)) : 64'(longint'(s));
		sq = mag * mag;
		if (sq > 64'(rcmp_pkg::POWER_MAX))
			sq = 64'(rcmp_pkg::POWER_MAX);
		refl = (m_reference == 0) ? 64'd1 : 64'(m_reference);
		pw64 = 64'(pw);
		c = (sq > pw64) ? 64'(m_attack) : 64'(m_release);
		d = 64'd16777216 - c;
		hi = c * (pw64 >> 24) + d * (sq >> 24);
		lo = c * (pw64 & 64'hFFFFFF) + d * (sq & 64'hFFFFFF);
		pw = 48'(hi + (lo >> 24));
		rms = int_sqrt(64'(pw) + 64'd110);
		if (!m_direction) begin
			gain = bound(int_sqrt((refl << 40) / rms), 64'(rcmp_pkg::ENC_GMIN),
				64'(rcmp_pkg::ENC_GMAX));
		end else begin
			qi = rms / refl;
			if (qi >= 400) begin
				gain = 64'(rcmp_pkg::DEC_GMAX);
			end else begin
				q = (qi << 40) + (((rms % refl) << 40) / refl);
				gain = bound(int_sqrt(q), 64'(rcmp_pkg::DEC_GMIN), 64'(rcmp_pkg::DEC_GMAX));
			end
		end
		prod = mag * gain;
		rnd = (prod + (64'd1 << 19)) >> 20;
		if (rnd > 64'h800000)
			rnd = 64'h800000;
		outv = (s < 0) ? -longint'(rnd) : longint'(rnd);
		if (outv > 64'sh7FFFFF)
			outv = 64'sh7FFFFF;
		return 24'(outv);
	endfunction

	function automatic pair_t predict_pair(pair_t p);
		pair_t r;
		r = p;
		if (m_enable) begin
			r.left = compand_channel(p.left, m_power_l);
			r.right = compand_channel(p.right, m_power_r);
		end
		return r;
	endfunction

	task automatic write_reg(logic [rcmp_pkg::IDX_W-1:0] idx, logic [23:0] val);
		cfg.index = idx;
		cfg.data = val;
		cfg.valid = 1'b1;
		do
			@(posedge clk);
		while (!cfg.ready);
		@(negedge clk);
		cfg.valid = 1'b0;
		case (idx)
			rcmp_pkg::CFG_ENABLE:    m_enable = val[0];
			rcmp_pkg::CFG_DIRECTION: m_direction = val[0];
			rcmp_pkg::CFG_ATTACK:    m_attack = val;
			rcmp_pkg::CFG_RELEASE:   m_release = val;
			rcmp_pkg::CFG_REFERENCE: m_reference = val[22:0];
			default: ;
		endcase
	endtask

	task automatic send_pair(pair_t p);
		while ($urandom_range(99) < send_idle_pct)
			@(negedge clk);
		sample_in.left_sample = p.left;
		sample_in.right_sample = p.right;
		sample_in.valid = 1'b1;
		expected_pairs.push_back(predict_pair(p));
		do
			@(posedge clk);
		while (!sample_in.ready);
		@(negedge clk);
		sample_in.valid = 1'b0;
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		while (expected_pairs.size() != 0 && guard < 200000) begin
			@(negedge clk);
			guard++;
		end
		repeat (400) @(negedge clk);
	endtask

	function automatic pair_t random_pair();
		pair_t p;
		case ($urandom_range(3))
			0: begin
				p.left = 24'($urandom);
				p.right = 24'($urandom);
			end
			1: begin
				p.left = 24'($signed(24'($urandom_range(65535))) - 32768);
				p.right = 24'($signed(24'($urandom_range(65535))) - 32768);
			end
			2: begin
				p.left = $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
				p.right = 24'($urandom_range(2000)) - 24'sd1000;
			end
			default: begin
				p.left = 24'($signed(24'($urandom_range(2097151))) - 1048576);
				p.right = -p.left;
			end
		endcase
		return p;
	endfunction

	always @(posedge clk) begin
		pair_t e;
		if (sample_out.valid && sample_out.ready) begin
			results_seen++;
			if (expected_pairs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: left %0d right %0d",
						sample_out.left_out, sample_out.right_out);
			end else begin
				e = expected_pairs.pop_front();
				if (e.left !== sample_out.left_out || e.right !== sample_out.right_out) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %0d/%0d got %0d/%0d", e.left, e.right,
							sample_out.left_out, sample_out.right_out);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (hold_off > 0) begin
			sample_out.ready <= 1'b0;
			hold_off <= hold_off - 1;
		end else begin
			sample_out.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	row_t dir_rows[$];

	initial begin
		row_t  row;
		pair_t p;
		int    phase;
		sample_in.valid = 1'b0;
		sample_in.left_sample = '0;
		sample_in.right_sample = '0;
		sample_out.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		hold_off = 0;
		mismatches = 0;
		results_seen = 0;
		send_idle_pct = 35;
		recv_idle_pct = 49;
		m_enable = 1'b1;
		m_direction = 1'b0;
		m_attack = rcmp_pkg::ATTACK_RESET;
		m_release = rcmp_pkg::RELEASE_RESET;
		m_reference = rcmp_pkg::REFERENCE_RESET;
		m_power_l = rcmp_pkg::POWER_RESET;
		m_power_r = rcmp_pkg::POWER_RESET;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// zeros after reset: gain times zero is zero; other rows are predicted
		dir_rows = '{
			'{24'sd0, 24'sd0, 1'b1, 24'sd0, 24'sd0},
			'{24'sh7FFFFF, 24'sh800000, 1'b0, 24'sd0, 24'sd0},
			'{24'sh800000, 24'sh7FFFFF, 1'b0, 24'sd0, 24'sd0},
			'{24'sd1, -24'sd1, 1'b0, 24'sd0, 24'sd0},
			'{24'sd1048576, -24'sd1048576, 1'b0, 24'sd0, 24'sd0},
			'{24'sd331350, 24'sd100, 1'b0, 24'sd0, 24'sd0}
		};
		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			p.left = row.left;
			p.right = row.right;
			send_pair(p);
			if (row.known)
				expected_pairs[$] = '{row.exp_left, row.exp_right};
		end
		drain();

		// pass-through: output equals input
		write_reg(rcmp_pkg::CFG_ENABLE, 24'hFFFFFE);
		dir_rows = '{
			'{24'sh7FFFFF, 24'sh800000, 1'b1, 24'sh7FFFFF, 24'sh800000},
			'{24'sh800000, 24'sd5, 1'b1, 24'sh800000, 24'sd5}
		};
		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			p.left = row.left;
			p.right = row.right;
			send_pair(p);
			expected_pairs[$] = '{row.exp_left, row.exp_right};
		end
		drain();

		// decode, zero reference treated as one, extreme coefficients, then one encode pair
		write_reg(rcmp_pkg::CFG_ENABLE, 24'd1);
		write_reg(rcmp_pkg::CFG_DIRECTION, 24'd1);
		write_reg(rcmp_pkg::CFG_REFERENCE, 24'd0);
		write_reg(rcmp_pkg::CFG_ATTACK, 24'd0);
		write_reg(rcmp_pkg::CFG_RELEASE, 24'hFFFFFF);
		p = '{24'sh7FFFFF, 24'sh800000};
		send_pair(p);
		p = '{24'sd3, -24'sd3};
		send_pair(p);
		drain();
		write_reg(CFG_UNUSED, 24'h123456);
		write_reg(rcmp_pkg::CFG_REFERENCE, 24'hFFFFFF);
		write_reg(rcmp_pkg::CFG_ATTACK, 24'hFFFFFF);
		write_reg(rcmp_pkg::CFG_RELEASE, 24'd0);
		p = '{24'sd1000, -24'sd4000000};
		send_pair(p);
		p = '{24'sh7FFFFF, 24'sd0};
		send_pair(p);
		drain();
		write_reg(rcmp_pkg::CFG_DIRECTION, 24'd0);
		p = '{24'sh800000, 24'sd1};
		send_pair(p);
		drain();

		// random phases: each phase picks new settings
		for (phase = 0; phase < 12; phase++) begin
			if (phase == 4) begin
				send_idle_pct = 49;
				recv_idle_pct = 35;
			end else if (phase == 8) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_reg(rcmp_pkg::CFG_ENABLE, 24'($urandom_range(5) != 0));
			write_reg(rcmp_pkg::CFG_DIRECTION, 24'($urandom_range(1)));
			write_reg(rcmp_pkg::CFG_ATTACK, $urandom_range(1) ? 24'($urandom) :
				24'hFFFFFF - 24'($urandom_range(100000)));
			write_reg(rcmp_pkg::CFG_RELEASE, $urandom_range(1) ? 24'($urandom) :
				24'hFFFFFF - 24'($urandom_range(10000)));
			write_reg(rcmp_pkg::CFG_REFERENCE, $urandom_range(3) == 0 ? 24'($urandom) :
				24'($urandom_range(1000000, 1)));
			if (phase == 9)
				hold_off = 2000;
			repeat (78) send_pair(random_pair());
			drain();
		end

		$display("Covered %0d result beats: directed extremes, 12 random settings,",
			results_seen);
		$display("encode, decode, bypass, idling on both sides and a long output stall.");
		if (mismatches == 0 && expected_pairs.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
`default_nettype wire
